[src/lbt_pkg.sv]
// Shared types, constants and helpers for the light-beam trip trigger.
// Used by lbt_cfg, lbt_seq and light_beam_trip_trigger; depends on nothing else.
`default_nettype none

package lbt_pkg;

  // Sample and timer widths.
  localparam int SAMPLE_BITS = 10;
  localparam int TIMER_BITS  = 16;
  localparam int LEVEL_BITS  = SAMPLE_BITS + 1;
  localparam int CFG_BITS    = 16;
  localparam int MARGIN_BITS = 10;

  localparam logic [LEVEL_BITS-1:0] MIN_START = LEVEL_BITS'(1) << SAMPLE_BITS;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // Stream widths, padded to whole bytes.
  localparam int IN_BITS        = SAMPLE_BITS + 1;
  localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS       = 3 + 3 + LEVEL_BITS + 1;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_DELAY = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRIP_MARGIN   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ARM_TIME      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLINK         = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FLASH_PULSE   = 3'd4;

  // Sequence phases.
  typedef enum logic [2:0] {
    PH_SETTLE  = 3'd0,
    PH_TRACK   = 3'd1,
    PH_LED_ON  = 3'd2,
    PH_LED_OFF = 3'd3,
    PH_WATCH   = 3'd4,
    PH_DELAY   = 3'd5,
    PH_FLASH   = 3'd6
  } phase_t;

  // Configuration register contents.
  typedef struct packed {
    logic [CFG_BITS-1:0]    trigger_delay_ms;
    logic [MARGIN_BITS-1:0] trip_margin;
    logic [CFG_BITS-1:0]    arm_time_ms;
    logic [CFG_BITS-1:0]    blink_ms;
    logic [CFG_BITS-1:0]    flash_pulse_ms;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic                  tripped;
    logic [LEVEL_BITS-1:0] reference_level;
    phase_t                phase;
    logic                  flash_on;
    logic                  led_on;
    logic                  laser_on;
  } res_t;

  // Limit a programmed length to what the phase timer can count.
  function automatic logic [TIMER_BITS-1:0] clamp_len(input logic [CFG_BITS-1:0] len);
    logic [TIMER_BITS-1:0] r;
    if (32'(len) > 32'(TIMER_MAX)) begin
      r = TIMER_MAX;
    end else begin
      r = TIMER_BITS'(len);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/light_beam_trip_trigger.sv]
// Light-beam trip trigger: one sample beat in, one status beat out, registered in the cycle after its sample.
// A new sample is taken in every clock cycle while the output register is free or being
// drained; the rate is set by the combinational update of phase, millisecond counter and
// reference minimum in lbt_seq. Each result shows the laser, LED and flash drives, the
// phase and the reference level after its sample, and flags the sample that trips the beam.
// Depends on lbt_pkg, lbt_cfg and lbt_seq.
`default_nettype none

module light_beam_trip_trigger
  import lbt_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Sample stream.
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,   // light_sample, ms_tick, zero pad
  // Status stream.
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [OUT_TDATA_BITS-1:0]      m_tdata,   // laser_on, led_on, flash_on, phase,
                                                    // reference_level, tripped, zero pad
  // Configuration writes.
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data
);

  cfg_t cfg;
  res_t res_next, out_res;
  logic out_valid, step;

  lbt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // A beat is taken whenever the output register is empty or being emptied.
  assign s_tready = !out_valid || m_tready;
  assign step     = s_tvalid && s_tready;

  lbt_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .light_sample (s_tdata[SAMPLE_BITS-1:0]),
    .ms_tick      (s_tdata[SAMPLE_BITS]),
    .cfg          (cfg),
    .res          (res_next)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_TDATA_BITS-OUT_BITS)'(0), out_res.tripped, out_res.reference_level,
                     out_res.phase, out_res.flash_on, out_res.led_on, out_res.laser_on};

`ifndef NO_ASSERTIONS
  // An accepted sample always leaves a result waiting in the next cycle.
  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("accepted sample produced no result");

  // A trip always enters the delay phase with the laser off.
  a_trip_phase: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.tripped) |-> (out_res.phase == PH_DELAY && !out_res.laser_on))
    else $error("trip without entering delay phase");

  // The LED and the flash are never driven together.
  a_led_flash: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_res.led_on && out_res.flash_on))
    else $error("LED and flash both driven");

  // The reference never rises above its restart value.
  a_ref_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.reference_level <= MIN_START))
    else $error("reference level out of range");
`endif

endmodule

`default_nettype wire

[src/lbt_cfg.sv]
// Configuration register file for the light-beam trip trigger.
// Depends on lbt_pkg for the register indexes and the cfg_t layout.
`default_nettype none

module lbt_cfg
  import lbt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data,
  output cfg_t                         cfg
);

  cfg_t regs;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.trigger_delay_ms <= CFG_BITS'(0);
      regs.trip_margin      <= MARGIN_BITS'(5);
      regs.arm_time_ms      <= CFG_BITS'(1000);
      regs.blink_ms         <= CFG_BITS'(50);
      regs.flash_pulse_ms   <= CFG_BITS'(100);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIGGER_DELAY: regs.trigger_delay_ms <= cfg_data;
        CFG_TRIP_MARGIN:   regs.trip_margin      <= cfg_data[MARGIN_BITS-1:0];
        CFG_ARM_TIME:      regs.arm_time_ms      <= cfg_data;
        CFG_BLINK:         regs.blink_ms         <= cfg_data;
        CFG_FLASH_PULSE:   regs.flash_pulse_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

[src/lbt_seq.sv]
// Trip-wire sequencer: phase, millisecond counter and reference minimum.
// Depends on lbt_pkg; state advances once per accepted input beat.
`default_nettype none

module lbt_seq
  import lbt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic [SAMPLE_BITS-1:0] light_sample,
  input  wire logic                   ms_tick,
  input  wire cfg_t                   cfg,
  output res_t                        res
);

  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] count, count_next, count_inc, len;
  logic [LEVEL_BITS-1:0] min_level, min_next, sample_ext;
  logic [LEVEL_BITS:0]   threshold;
  logic                  trip_hit, tripped;

  assign sample_ext = LEVEL_BITS'(light_sample);

  // Signed compare: sample below minimum minus margin; negative threshold never trips.
  assign threshold = {1'b0, min_level} - (LEVEL_BITS+1)'(cfg.trip_margin);
  assign trip_hit  = $signed({2'b00, light_sample}) < $signed(threshold);

  // Length of the current timed phase.
  always_comb begin
    unique case (phase)
      PH_LED_ON, PH_LED_OFF: len = clamp_len(cfg.blink_ms);
      PH_DELAY:              len = clamp_len(cfg.trigger_delay_ms);
      PH_FLASH:              len = clamp_len(cfg.flash_pulse_ms);
      default:               len = clamp_len(cfg.arm_time_ms >> 1);
    endcase
  end

  // Saturating millisecond count.
  assign count_inc = (ms_tick && count != TIMER_MAX) ? count + TIMER_BITS'(1) : count;

  // Next state for one sample.
  always_comb begin
    phase_next = phase;
    count_next = count;
    min_next   = min_level;
    tripped    = 1'b0;
    case (phase)
      PH_WATCH: begin
        if (trip_hit) begin
          tripped    = 1'b1;
          phase_next = PH_DELAY;
          count_next = '0;
        end
      end
      default: begin
        if (phase == PH_TRACK && sample_ext < min_level) begin
          min_next = sample_ext;
        end
        count_next = count_inc;
        if (count_inc >= len) begin
          count_next = '0;
          if (phase == PH_FLASH) begin
            phase_next = PH_SETTLE;
            min_next   = MIN_START;
          end else begin
            phase_next = phase_t'(3'(phase + 3'd1));
          end
        end
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SETTLE;
      count     <= '0;
      min_level <= MIN_START;
    end else if (step) begin
      phase     <= phase_next;
      count     <= count_next;
      min_level <= min_next;
    end
  end

  // Result fields show the state after this sample.
  always_comb begin
    res.laser_on        = (phase_next == PH_SETTLE) || (phase_next == PH_TRACK) ||
                          (phase_next == PH_LED_ON) || (phase_next == PH_LED_OFF) ||
                          (phase_next == PH_WATCH);
    res.led_on          = (phase_next == PH_LED_ON);
    res.flash_on        = (phase_next == PH_FLASH);
    res.phase           = phase_next;
    res.reference_level = min_next;
    res.tripped         = tripped;
  end

endmodule

`default_nettype wire

[tb/lbt_status_checker.sv]
// Checker for the light-beam trip trigger: watches the sample, status and configuration ports.
// It predicts every status beat from its own copy of the sequence and compares it with the DUT.
// Depends on lbt_pkg for stream widths, phase codes, register indexes and the status layout.
`timescale 1ns / 1ps

module lbt_status_checker
  import lbt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [OUT_TDATA_BITS-1:0] m_tdata,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  output int                        fail_count,
  output int                        beats_due
);

  // Register copies, written as the DUT sees them.
  logic [CFG_BITS-1:0]    trig_delay;
  logic [MARGIN_BITS-1:0] margin;
  logic [CFG_BITS-1:0]    arm_ms;
  logic [CFG_BITS-1:0]    blink_len;
  logic [CFG_BITS-1:0]    flash_len;

  // Sequence state of the predicted block.
  phase_t                cur_phase;
  logic [TIMER_BITS-1:0] ms_count;
  logic [LEVEL_BITS-1:0] min_level;

  // Status beats still owed by the DUT, oldest first.
  res_t status_q[$];

  initial begin
    fail_count = 0;
    beats_due  = 0;
  end

  // Length of a timed phase in milliseconds; settle and tracking share half the arm time.
  function automatic logic [TIMER_BITS-1:0] phase_len(input phase_t p);
    logic [TIMER_BITS-1:0] len;
    case (p)
      PH_LED_ON, PH_LED_OFF: len = blink_len;
      PH_DELAY:              len = trig_delay;
      PH_FLASH:              len = flash_len;
      default:               len = arm_ms >> 1;
    endcase
    return len;
  endfunction

  // Advance the sequence by one sample and return the status it leaves behind.
  function automatic res_t next_status(input logic [SAMPLE_BITS-1:0] sample, input logic tick);
    res_t   st;
    phase_t p;
    logic   trip;
    int     threshold;
    p    = cur_phase;
    trip = 1'b0;
    if (p == PH_WATCH) begin
      // Signed compare: a margin above the minimum can never trip.
      threshold = int'(min_level) - int'(margin);
      if (int'(sample) < threshold) begin
        trip     = 1'b1;
        p        = PH_DELAY;
        ms_count = '0;
      end
    end else begin
      if (p == PH_TRACK && {1'b0, sample} < min_level) begin
        min_level = {1'b0, sample};
      end
      if (tick && ms_count != TIMER_MAX) begin
        ms_count = ms_count + 1'b1;
      end
      // A zero length still holds the phase for exactly one sample.
      if (ms_count >= phase_len(p)) begin
        ms_count = '0;
        if (p == PH_FLASH) begin
          p         = PH_SETTLE;
          min_level = MIN_START;
        end else begin
          p = phase_t'(p + 3'd1);
        end
      end
    end
    cur_phase          = p;
    st.laser_on        = (p <= PH_WATCH);
    st.led_on          = (p == PH_LED_ON);
    st.flash_on        = (p == PH_FLASH);
    st.phase           = p;
    st.reference_level = min_level;
    st.tripped         = trip;
    return st;
  endfunction

  always @(posedge clk) begin
    res_t                           want;
    res_t                           got;
    logic [OUT_TDATA_BITS-1:0] pad;
    if (rst) begin
      trig_delay = '0;
      margin     = MARGIN_BITS'(5);
      arm_ms     = CFG_BITS'(1000);
      blink_len  = CFG_BITS'(50);
      flash_len  = CFG_BITS'(100);
      cur_phase  = PH_SETTLE;
      ms_count   = '0;
      min_level  = MIN_START;
      status_q.delete();
    end else begin
      // Status beats are matched before new samples are queued, so a beat cannot
      // pair with a sample taken at the same edge.
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[OUT_BITS-1:0]);
        pad = m_tdata >> OUT_BITS;
        if (status_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: status beat with nothing expected: %h", $realtime, m_tdata);
          end
          fail_count++;
        end else begin
          want = status_q.pop_front();
          if (got.laser_on !== want.laser_on || got.led_on !== want.led_on ||
              got.flash_on !== want.flash_on || got.phase !== want.phase ||
              got.reference_level !== want.reference_level ||
              got.tripped !== want.tripped || pad !== '0) begin
            if (fail_count < 10) begin
              $display(
                "%0t: status expected laser %0d led %0d flash %0d phase %0d level %0d trip %0d",
                $realtime, want.laser_on, want.led_on, want.flash_on, want.phase,
                want.reference_level, want.tripped);
              $display(
                "%0t: status actual   laser %0d led %0d flash %0d phase %0d level %0d trip %0d %s %h",
                $realtime, got.laser_on, got.led_on, got.flash_on, got.phase,
                got.reference_level, got.tripped, "pad", pad);
            end
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        status_q.push_back(next_status(s_tdata[SAMPLE_BITS-1:0], s_tdata[SAMPLE_BITS]));
      end
      // Register writes apply from the next sample; indexes past the last register are dropped.
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRIGGER_DELAY: trig_delay = cfg_data;
          CFG_TRIP_MARGIN:   margin     = cfg_data[MARGIN_BITS-1:0];
          CFG_ARM_TIME:      arm_ms     = cfg_data;
          CFG_BLINK:         blink_len  = cfg_data;
          CFG_FLASH_PULSE:   flash_len  = cfg_data;
          default: ;
        endcase
      end
    end
    beats_due = status_q.size();
  end

endmodule

[tb/tb.sv]
// Testbench top for the light-beam trip trigger: clock, reset, sample stimulus and the verdict.
// Drives directed sequences, then random register settings with random sample runs.
// Depends on lbt_pkg, light_beam_trip_trigger and lbt_status_checker.
`timescale 1ns / 1ps

module tb;
  import lbt_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int STEADY_FROM  = 500;
  localparam int STEADY_TO    = 800;
  localparam int LAST_INDEX   = (1 << CFG_IDX_BITS) - 1;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      s_tvalid  = 1'b0;
  logic [IN_TDATA_BITS-1:0]  s_tdata   = '0;
  logic                      m_tready  = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index = CFG_TRIGGER_DELAY;
  logic [CFG_BITS-1:0]       cfg_data  = '0;
  wire                       s_tready;
  wire                       m_tvalid;
  wire [OUT_TDATA_BITS-1:0]  m_tdata;
  int                        fail_count;
  int                        beats_due;
  int                        random_sent = 0;
  int                        cycle_count = 0;
  bit                        steady      = 1'b0;

  light_beam_trip_trigger dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lbt_status_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .beats_due  (beats_due)
  );

  always #5 clk = ~clk;

  // The status side stalls at random, except through the steady stretch.
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 15);
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("light_beam_trip_trigger: mismatch");
      $finish;
    end
  end

  // Offer one sample beat, with a random gap ahead of it, and wait until it is taken.
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] sample, input logic tick);
    while (!steady && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_BITS'({tick, sample});
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop sending and wait until every status beat is back and the pipeline is empty.
  task automatic drain(input int extra);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (beats_due != 0);
    repeat (extra) @(posedge clk);
  endtask

  // One register write; the caller lowers the write enable after its last write.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Pick a fresh setting: mostly short phases so the sequence cycles, sometimes the extremes.
  task automatic pick_setting();
    int pick;
    pick = $urandom_range(7);
    write_reg(CFG_TRIGGER_DELAY, (pick == 0) ? 16'hFFFF :
              (pick == 1) ? 16'd0 : 16'($urandom_range(0, 8)));
    pick = $urandom_range(9);
    write_reg(CFG_TRIP_MARGIN, (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
              (pick == 2) ? 16'($urandom) : 16'($urandom_range(0, 200)));
    pick = $urandom_range(9);
    write_reg(CFG_ARM_TIME, (pick == 0) ? 16'd2 : (pick == 1) ? 16'd3 :
              (pick == 2) ? 16'hFFFF : (pick == 3) ? 16'($urandom_range(100, 400)) :
              16'($urandom_range(2, 40)));
    pick = $urandom_range(9);
    write_reg(CFG_BLINK, (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
              16'($urandom_range(0, 6)));
    pick = $urandom_range(9);
    write_reg(CFG_FLASH_PULSE, (pick == 0) ? 16'd1 : (pick == 1) ? 16'hFFFF :
              16'($urandom_range(1, 8)));
    // Writes to an index past the last register must leave everything alone.
    if ($urandom_range(3) == 0) begin
      write_reg(CFG_IDX_BITS'($urandom_range(CFG_FLASH_PULSE + 1, LAST_INDEX)),
                16'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int seg_len;
    int tick_pct;
    int dip_pct;
    int roll;
    logic [SAMPLE_BITS-1:0] sample;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Settings left at their reset values: the block sits in the settle phase.
    push_sample(10'd1023, 1'b1);
    push_sample(10'd0, 1'b0);
    push_sample(10'd512, 1'b1);
    drain(2);

    // Shortest phases and no margin: one full trip and re-arm, with zero-length phases.
    write_reg(CFG_ARM_TIME, 16'd2);
    write_reg(CFG_TRIP_MARGIN, 16'd0);
    write_reg(CFG_BLINK, 16'd0);
    write_reg(CFG_TRIGGER_DELAY, 16'd0);
    write_reg(CFG_FLASH_PULSE, 16'd1);
    cfg_we <= 1'b0;
    push_sample(10'd500, 1'b1);
    push_sample(10'd1023, 1'b1);
    push_sample(10'd0, 1'b0);
    push_sample(10'd0, 1'b0);
    push_sample(10'd1023, 1'b0);
    push_sample(10'd1022, 1'b0);
    push_sample(10'd0, 1'b0);
    push_sample(10'd0, 1'b0);
    push_sample(10'd0, 1'b1);
    drain(2);

    // Margin above the minimum gives a negative threshold, so nothing trips.
    write_reg(CFG_TRIP_MARGIN, 16'hFFFF);
    write_reg(CFG_ARM_TIME, 16'd3);
    cfg_we <= 1'b0;
    push_sample(10'd900, 1'b1);
    push_sample(10'd5, 1'b1);
    push_sample(10'd1023, 1'b0);
    push_sample(10'd0, 1'b0);
    push_sample(10'd0, 1'b1);
    drain(2);

    // A threshold of exactly one lets a zero sample trip, then the flash and re-arm.
    write_reg(CFG_IDX_BITS'(CFG_FLASH_PULSE + 1), 16'hFFFF);
    write_reg(CFG_TRIP_MARGIN, 16'd4);
    cfg_we <= 1'b0;
    push_sample(10'd0, 1'b0);
    push_sample(10'd1023, 1'b1);
    push_sample(10'd1023, 1'b1);
    drain(2);

    // Random settings, each followed by a run of samples: mostly a steady light level
    // with occasional dips that can break the beam.
    while (random_sent < RANDOM_ITEMS) begin
      pick_setting();
      seg_len  = $urandom_range(40, 100);
      tick_pct = $urandom_range(20, 100);
      dip_pct  = $urandom_range(2, 12);
      for (int i = 0; i < seg_len; i++) begin
        roll = $urandom_range(99);
        if (roll < dip_pct) begin
          sample = SAMPLE_BITS'($urandom_range(0, 300));
        end else if (roll < dip_pct + 5) begin
          sample = SAMPLE_BITS'($urandom);
        end else begin
          sample = SAMPLE_BITS'($urandom_range(700, 1023));
        end
        steady = (random_sent >= STEADY_FROM && random_sent < STEADY_TO);
        push_sample(sample, ($urandom_range(99) < tick_pct));
        random_sent++;
      end
      drain(2);
    end

    drain(5);
    if (fail_count == 0) begin
      $display("light_beam_trip_trigger: match");
    end else begin
      $display("light_beam_trip_trigger: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
src/lbt_pkg.sv
src/lbt_cfg.sv
src/lbt_seq.sv
src/light_beam_trip_trigger.sv
tb/lbt_status_checker.sv
tb/tb.sv
